// ===== sv/aes_ctr_pkg.sv =====
package aes_ctr_pkg;

  localparam int NumRoundWords = 44;
  localparam int NumRounds = 10;
  localparam logic [31:0] CounterStart = 32'h0000_0001;
  localparam int QueueDepth = 4;

  localparam logic [1:0] RegKeyLow = 2'd0;
  localparam logic [1:0] RegKeyHigh = 2'd1;
  localparam logic [1:0] RegNonceLow = 2'd2;
  localparam logic [1:0] RegNonceHigh = 2'd3;

  typedef struct packed {
    logic        end_of_packet;
    logic [3:0]  byte_count;
    logic [63:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic        out_end_of_packet;
    logic [3:0]  out_byte_count;
    logic [63:0] data_out;
  } out_word_t;

  // classified word handed from front to back
  typedef struct packed {
    logic        first_half;
    logic [3:0]  count;
    logic        eop;
    logic [63:0] data;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the state sits in bits 8*i+7:8*i
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = sbox(s[8*(r+4*((c+r)%4)) +: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
      t[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      t[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // next round key (four words) from the previous one
  function automatic logic [127:0] next_round_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t = k[127:96];
    t = {t[7:0], t[31:8]};
    t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])} ^ {24'h0, rc};
    w0 = k[31:0] ^ t;
    w1 = k[63:32] ^ w0;
    w2 = k[95:64] ^ w1;
    w3 = k[127:96] ^ w2;
    return {w3, w2, w1, w0};
  endfunction

endpackage

// ===== sv/aes128_counter_mode_stream_unit.sv =====
// aes-128 counter mode over packets carried in 8-byte words
// input channel: push a word (data, byte count, end mark) while full is low
// result channel: one word per input word, in order, shown while empty is low,
//   taken with pop; results may wait while further words are queued
// configuration: apb-style port, 64-bit data, registers at byte addresses 8*i
//   (key low, key high, nonce low, nonce high); writing a nonce register
//   reloads the block counter to one and restarts at the first half
// throughput: one aes block per two words; the round unit is loaded, runs ten
//   rounds and hands the keystream over, then the first-half word is taken
//   once the result register is free and the second-half word after it; the
//   next block is loaded only after the second-half word is taken; a packet
//   that ends on a first-half word uses a whole block for that word
// the front queue holds four words so input is taken while the back stalls
// reset: counter one, first half, all queues empty, keys and nonce zero
// if pop stays low, one result is held and the queue fills, then full rises
module aes128_counter_mode_stream_unit #(
  parameter int QDepth = aes_ctr_pkg::QueueDepth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  aes_ctr_pkg::in_word_t  in_word,
  output logic                   out_empty,
  input  logic                   out_pop,
  output aes_ctr_pkg::out_word_t out_word,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [4:0]             cfg_paddr,
  input  logic [63:0]            cfg_pwdata,
  output logic [63:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic [63:0] key_lo_r, key_hi_r, nonce_lo_r;
  logic [31:0] nonce_hi_r;
  logic        wr, restart, job_pop, job_empty;
  logic [1:0]  ridx;
  aes_ctr_pkg::job_t job;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx = cfg_paddr[4:3];
  assign restart = wr && (ridx == aes_ctr_pkg::RegNonceLow ||
                          ridx == aes_ctr_pkg::RegNonceHigh);

  // register read
  always_comb begin
    unique case (ridx)
      aes_ctr_pkg::RegKeyLow:   cfg_prdata = key_lo_r;
      aes_ctr_pkg::RegKeyHigh:  cfg_prdata = key_hi_r;
      aes_ctr_pkg::RegNonceLow: cfg_prdata = nonce_lo_r;
      default:                  cfg_prdata = {32'h0, nonce_hi_r};
    endcase
  end

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r   <= '0;
      key_hi_r   <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
    end else if (wr) begin
      unique case (ridx)
        aes_ctr_pkg::RegKeyLow:   key_lo_r   <= cfg_pwdata;
        aes_ctr_pkg::RegKeyHigh:  key_hi_r   <= cfg_pwdata;
        aes_ctr_pkg::RegNonceLow: nonce_lo_r <= cfg_pwdata;
        default:                  nonce_hi_r <= cfg_pwdata[31:0];
      endcase
    end
  end

  aes_ctr_front #(.QDepth(QDepth)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_word, .restart,
    .job_pop, .job_empty, .job
  );

  aes_ctr_back u_back (
    .clk, .rst_n,
    .key({key_hi_r, key_lo_r}),
    .nonce({nonce_hi_r, nonce_lo_r}),
    .restart, .job_empty, .job, .job_pop,
    .out_empty, .out_pop, .out_word
  );

endmodule

// ===== sv/aes_ctr_front.sv =====
module aes_ctr_front #(
  parameter int QDepth = aes_ctr_pkg::QueueDepth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  aes_ctr_pkg::in_word_t in_word,
  input  logic                  restart,
  input  logic                  job_pop,
  output logic                  job_empty,
  output aes_ctr_pkg::job_t     job
);

  localparam int AW = $clog2(QDepth);

  aes_ctr_pkg::job_t q_r [QDepth];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          half_r, half_nxt;
  logic          acc;
  logic [3:0]    cnt_clip;

  assign in_full   = (cnt_r == (AW+1)'(QDepth));
  assign job_empty = (cnt_r == '0);
  assign job       = q_r[rp_r];
  assign acc       = in_push && !in_full;
  assign cnt_clip  = in_word.byte_count[3] ? 4'd8 : in_word.byte_count;

  // classify: which half of the counter block this word uses
  always_comb begin
    half_nxt = half_r;
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    cnt_nxt  = cnt_r;
    if (acc) begin
      half_nxt = !half_r && !in_word.end_of_packet;
      wp_nxt   = (wp_r == AW'(QDepth-1)) ? '0 : wp_r + 1'b1;
    end
    if (restart) begin
      half_nxt = 1'b0;
    end
    if (job_pop && !job_empty) begin
      rp_nxt = (rp_r == AW'(QDepth-1)) ? '0 : rp_r + 1'b1;
    end
    cnt_nxt = cnt_r + (AW+1)'(acc) - (AW+1)'(job_pop && !job_empty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
    end else begin
      half_r <= half_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wp_r] <= '{first_half: !half_r, count: cnt_clip,
                     eop: in_word.end_of_packet, data: in_word.data_in};
    end
  end

endmodule

// ===== sv/aes_ctr_core.sv =====
module aes_ctr_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] key,
  input  logic [127:0] blk,
  output logic         busy,
  output logic         done,
  output logic [127:0] result
);

  logic [127:0] st_r, st_nxt, rk_r, rk_nxt;
  logic [7:0]   rc_r, rc_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         busy_r, busy_nxt, done_r, done_nxt;
  logic [127:0] ss, nk;

  assign ss     = aes_ctr_pkg::sub_shift(st_r);
  assign nk     = aes_ctr_pkg::next_round_key(rk_r, rc_r);
  assign busy   = busy_r;
  assign done   = done_r;
  assign result = st_r;

  // one round per cycle, round key expanded on the fly
  always_comb begin
    st_nxt   = st_r;
    rk_nxt   = rk_r;
    rc_nxt   = rc_r;
    rnd_nxt  = rnd_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      st_nxt   = blk ^ key;
      rk_nxt   = key;
      rc_nxt   = 8'h01;
      rnd_nxt  = 4'd1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rk_nxt  = nk;
      rc_nxt  = aes_ctr_pkg::xtime(rc_r);
      rnd_nxt = rnd_r + 4'd1;
      if (rnd_r == 4'(aes_ctr_pkg::NumRounds)) begin
        st_nxt   = ss ^ nk;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        st_nxt = aes_ctr_pkg::mix_columns(ss) ^ nk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r  <= st_nxt;
    rk_r  <= rk_nxt;
    rc_r  <= rc_nxt;
    rnd_r <= rnd_nxt;
  end

endmodule

// ===== sv/aes_ctr_back.sv =====
module aes_ctr_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [127:0]           key,
  input  logic [95:0]            nonce,
  input  logic                   restart,
  input  logic                   job_empty,
  input  aes_ctr_pkg::job_t      job,
  output logic                   job_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output aes_ctr_pkg::out_word_t out_word
);

  logic [31:0]  ctr_r, ctr_nxt;
  logic [127:0] ks_r;
  logic         ks_ok_r, ks_ok_nxt;
  logic         run_r, run_nxt;
  logic         ov_r, ov_nxt;
  aes_ctr_pkg::out_word_t ow_r;
  logic         start, busy, done, use_ks;
  logic [127:0] res, blk;
  logic [63:0]  half, mask;
  logic         slot_free;

  assign blk = {ctr_r[7:0], ctr_r[15:8], ctr_r[23:16], ctr_r[31:24], nonce};

  aes_ctr_core u_core (
    .clk, .rst_n, .start, .key, .blk, .busy, .done, .result(res)
  );

  // keystream is usable for a first-half word only after a fresh block
  assign slot_free = !ov_r || out_pop;
  assign use_ks    = !job_empty && slot_free &&
                     (job.first_half ? (ks_ok_r && !run_r) : 1'b1);
  assign start     = !job_empty && job.first_half && !ks_ok_r && !run_r && !busy;
  assign job_pop   = use_ks;
  assign half      = job.first_half ? ks_r[63:0] : ks_r[127:64];
  assign out_empty = !ov_r;
  assign out_word  = ow_r;

  always_comb begin
    mask = '0;
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = (4'(i) < job.count) ? 8'hff : 8'h00;
    end
  end

  // counter, keystream validity and output register control
  always_comb begin
    ctr_nxt   = ctr_r;
    ks_ok_nxt = ks_ok_r;
    run_nxt   = run_r;
    ov_nxt    = ov_r;
    if (start) begin
      run_nxt = 1'b1;
    end
    if (done) begin
      run_nxt   = 1'b0;
      ks_ok_nxt = 1'b1;
    end
    if (use_ks) begin
      if (job.first_half) begin
        ks_ok_nxt = 1'b0;
      end
      if (!job.first_half || job.eop) begin
        ctr_nxt = ctr_r + 32'd1;
      end
      ov_nxt = 1'b1;
    end else if (out_pop && ov_r) begin
      ov_nxt = 1'b0;
    end
    if (restart) begin
      ctr_nxt = aes_ctr_pkg::CounterStart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r   <= aes_ctr_pkg::CounterStart;
      ks_ok_r <= 1'b0;
      run_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      ctr_r   <= ctr_nxt;
      ks_ok_r <= ks_ok_nxt;
      run_r   <= run_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // keystream and result words
  always_ff @(posedge clk) begin
    if (done) begin
      ks_r <= res;
    end
    if (use_ks) begin
      ow_r <= '{out_end_of_packet: job.eop, out_byte_count: job.count,
                data_out: (job.data ^ half) & mask};
    end
  end

endmodule

// ===== tb/aes_ctr_checker.sv =====
`timescale 1ns / 1ps

module aes_ctr_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic                   in_full,
  input  aes_ctr_pkg::in_word_t  in_word,
  input  logic                   out_empty,
  input  logic                   out_pop,
  input  aes_ctr_pkg::out_word_t out_word,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic                   cfg_pready,
  input  logic [4:0]             cfg_paddr,
  input  logic [63:0]            cfg_pwdata,
  output int                     fails,
  output int                     pending
);

  logic [7:0]  sub_tab [256];
  logic [63:0] key_lo, key_hi, nonce_lo;
  logic [31:0] nonce_hi;
  logic [31:0] key_words [44];
  logic [31:0] ctr;
  logic        second_half;
  logic [127:0] pad;
  aes_ctr_pkg::out_word_t expected_words [$];

  // gf(2^8) arithmetic for building the substitution table
  function automatic logic [7:0] dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = dbl(a);
    end
    return acc;
  endfunction

  initial begin
    logic [7:0] inv, s;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++) begin
        if (gf_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
      end
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tab[a] = s;
    end
  end

  // key schedule, lowest key byte in bits 7:0 of each word
  task automatic build_schedule();
    logic [31:0] t;
    logic [7:0]  rcon;
    rcon = 8'h01;
    key_words[0] = key_lo[31:0];
    key_words[1] = key_lo[63:32];
    key_words[2] = key_hi[31:0];
    key_words[3] = key_hi[63:32];
    for (int i = 4; i < 44; i++) begin
      t = key_words[i-1];
      if (i % 4 == 0) begin
        t = {t[7:0], t[31:8]};
        t = {sub_tab[t[31:24]], sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]]};
        t[7:0] ^= rcon;
        rcon = dbl(rcon);
      end
      key_words[i] = key_words[i-4] ^ t;
    end
  endtask

  // one aes-128 encryption, byte i of the block in bits 8*i+7:8*i
  function automatic logic [127:0] encipher(input logic [127:0] blk);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) st[i] = blk[8*i +: 8] ^ key_words[i/4][8*(i%4) +: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) tmp[r+4*c] = sub_tab[st[r+4*((c+r)%4)]];
      end
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          tmp[4*c]   = a0 ^ x ^ dbl(a0 ^ a1);
          tmp[4*c+1] = a1 ^ x ^ dbl(a1 ^ a2);
          tmp[4*c+2] = a2 ^ x ^ dbl(a2 ^ a3);
          tmp[4*c+3] = a3 ^ x ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ key_words[4*rnd + i/4][8*(i%4) +: 8];
    end
    for (int i = 0; i < 16; i++) res[8*i +: 8] = st[i];
    return res;
  endfunction

  // expected result for one accepted word, advancing the counter state
  task automatic predict_cipher_word(input aes_ctr_pkg::in_word_t w);
    aes_ctr_pkg::out_word_t r;
    logic [3:0]  cnt;
    logic [63:0] mask;
    cnt = (w.byte_count > 4'd8) ? 4'd8 : w.byte_count;
    if (!second_half)
      pad = encipher({ctr[7:0], ctr[15:8], ctr[23:16], ctr[31:24], nonce_hi, nonce_lo});
    mask = (cnt == 4'd8) ? '1 : ((64'd1 << (8 * cnt)) - 64'd1);
    r.data_out = (w.data_in ^ (second_half ? pad[127:64] : pad[63:0])) & mask;
    r.out_byte_count = cnt;
    r.out_end_of_packet = w.end_of_packet;
    expected_words.push_back(r);
    if (second_half || w.end_of_packet) begin
      ctr = ctr + 32'd1;
      second_half = 1'b0;
    end else begin
      second_half = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    aes_ctr_pkg::out_word_t e;
    if (!rst_n) begin
      fails = 0;
      key_lo = '0;
      key_hi = '0;
      nonce_lo = '0;
      nonce_hi = '0;
      ctr = aes_ctr_pkg::CounterStart;
      second_half = 1'b0;
      build_schedule();
      expected_words.delete();
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          aes_ctr_pkg::RegKeyLow: begin
            key_lo = cfg_pwdata;
            build_schedule();
          end
          aes_ctr_pkg::RegKeyHigh: begin
            key_hi = cfg_pwdata;
            build_schedule();
          end
          aes_ctr_pkg::RegNonceLow: begin
            nonce_lo = cfg_pwdata;
            ctr = aes_ctr_pkg::CounterStart;
            second_half = 1'b0;
          end
          aes_ctr_pkg::RegNonceHigh: begin
            nonce_hi = cfg_pwdata[31:0];
            ctr = aes_ctr_pkg::CounterStart;
            second_half = 1'b0;
          end
          default: ;
        endcase
      end
      if (in_push && !in_full) predict_cipher_word(in_word);
      // compare an accepted result word with the oldest expectation
      if (out_pop && !out_empty) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: %h", out_word);
          fails++;
        end else begin
          e = expected_words.pop_front();
          if (out_word.data_out !== e.data_out) begin
            $error("data_out: expected %h actual %h", e.data_out, out_word.data_out);
            fails++;
          end
          if (out_word.out_byte_count !== e.out_byte_count) begin
            $error("out_byte_count: expected %0d actual %0d",
                   e.out_byte_count, out_word.out_byte_count);
            fails++;
          end
          if (out_word.out_end_of_packet !== e.out_end_of_packet) begin
            $error("out_end_of_packet: expected %b actual %b",
                   e.out_end_of_packet, out_word.out_end_of_packet);
            fails++;
          end
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  aes_ctr_pkg::in_word_t  in_word;
  logic        out_empty;
  logic        out_pop;
  aes_ctr_pkg::out_word_t out_word;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]  cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;
  int          fails;
  int          pending;
  int          send_idle_pct;
  int          recv_stall_pct;

  aes128_counter_mode_stream_unit u_top (
    .clk, .rst_n, .in_push, .in_full, .in_word, .out_empty, .out_pop, .out_word,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata,
    .cfg_pready
  );

  aes_ctr_checker u_checker (
    .clk, .rst_n, .in_push, .in_full, .in_word, .out_empty, .out_pop, .out_word,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .fails, .pending
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // receiver: random stalls on pop
  always @(negedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // offer one word, with an optional idle gap first; returns at a falling edge
  task automatic send_word(input logic [63:0] d, input logic [3:0] cnt, input logic eop);
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_word <= '{end_of_packet: eop, byte_count: cnt, data_in: d};
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  // stop sending and wait for every expected word to come back
  task automatic drain();
    in_push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly well-formed packets, some noise words
  task automatic random_traffic(input int n_words);
    int sent, len;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 15) begin
        send_word(rand64(), 4'($urandom_range(15)), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if (i == len - 1) send_word(rand64(), 4'($urandom_range(1, 8)), 1'b1);
          else send_word(rand64(), 4'd8, 1'b0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    in_push = 1'b0;
    in_word = '0;
    out_pop = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words under the reset key and nonce
    send_word(64'h0, 4'd8, 1'b0);
    send_word('1, 4'd8, 1'b1);
    send_word('1, 4'd1, 1'b1);
    send_word(rand64(), 4'd0, 1'b0);
    send_word(rand64(), 4'd15, 1'b0);
    send_word(rand64(), 4'd9, 1'b1);
    send_word('1, 4'd7, 1'b0);
    send_word(rand64(), 4'd3, 1'b1);
    send_word(rand64(), 4'd0, 1'b1);
    // key change between the two halves of a block
    send_word(rand64(), 4'd8, 1'b0);
    drain();
    reg_write(aes_ctr_pkg::RegKeyLow, '1);
    send_word(rand64(), 4'd8, 1'b0);
    send_word(rand64(), 4'd5, 1'b1);
    drain();

    // phases with different settings and idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          reg_write(aes_ctr_pkg::RegKeyHigh, '1);
          reg_write(aes_ctr_pkg::RegNonceLow, '1);
          reg_write(aes_ctr_pkg::RegNonceHigh, 64'hffff_ffff);
        end
        1: begin
          send_idle_pct = 57; recv_stall_pct = 0;
          reg_write(aes_ctr_pkg::RegKeyLow, rand64());
          reg_write(aes_ctr_pkg::RegKeyHigh, rand64());
          reg_write(aes_ctr_pkg::RegNonceLow, rand64());
          reg_write(aes_ctr_pkg::RegNonceHigh, {32'h0, $urandom});
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 57;
          reg_write(aes_ctr_pkg::RegKeyLow, '0);
          reg_write(aes_ctr_pkg::RegKeyHigh, '0);
          reg_write(aes_ctr_pkg::RegNonceLow, '0);
          reg_write(aes_ctr_pkg::RegNonceHigh, '0);
        end
        default: begin
          send_idle_pct = 12; recv_stall_pct = 12;
          reg_write(aes_ctr_pkg::RegKeyLow, rand64());
          reg_write(aes_ctr_pkg::RegKeyHigh, rand64());
          reg_write(aes_ctr_pkg::RegNonceHigh, {32'h0, $urandom});
        end
      endcase
      random_traffic(185);
      drain();
    end

    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // overall run limit
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
